[rtl/awqd_pkg.sv]
// ============================================================================
// awqd_pkg
// Shared types and constants for the alpha-weighted quad downsampler.
// ============================================================================
package awqd_pkg;

    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int DEN_W      = 9;
    localparam int PROD_W     = 16;
    localparam int NUM_W      = 17;
    localparam int QBITS      = 8;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QBITS / DIV_BITS;

    // Registers inside one lane: product stage, sum stage, divider stages.
    localparam int LANE_LAT   = DIV_STAGES + 2;
    // Lane latency plus the merge register.
    localparam int PIPE_LAT   = LANE_LAT + 1;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    // Marks a pair whose two alphas were both zero.
    typedef struct packed {
        logic top_clear;
        logic bot_clear;
    } pair_flags_t;

endpackage

[rtl/awqd_lane.sv]
// ============================================================================
// awqd_lane
// One color channel of one pixel pair: alpha-weighted mean with a pipelined
// restoring divider.
// ============================================================================
module awqd_lane
(
    input  logic                         clk,
    input  logic                         ce,
    input  logic [awqd_pkg::CHAN_W-1:0]  cp,
    input  logic [awqd_pkg::CHAN_W-1:0]  cq,
    input  logic [awqd_pkg::CHAN_W-1:0]  wp,
    input  logic [awqd_pkg::CHAN_W-1:0]  wq,
    output logic [awqd_pkg::QBITS-1:0]   q
);

    localparam int NUM_W  = awqd_pkg::NUM_W;
    localparam int DEN_W  = awqd_pkg::DEN_W;
    localparam int PROD_W = awqd_pkg::PROD_W;
    localparam int QBITS  = awqd_pkg::QBITS;
    localparam int NSTG   = awqd_pkg::DIV_STAGES;
    localparam int NBITS  = awqd_pkg::DIV_BITS;

    logic                          both_zero;
    logic [awqd_pkg::CHAN_W-1:0]   wp_eff;
    logic [awqd_pkg::CHAN_W-1:0]   wq_eff;

    logic [PROD_W-1:0] prodp_reg;
    logic [PROD_W-1:0] prodq_reg;
    logic [DEN_W-1:0]  dena_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  denb_reg;

    logic [NUM_W-1:0]  rem_reg [NSTG-1];
    logic [DEN_W-1:0]  dvs_reg [NSTG-1];
    logic [QBITS-1:0]  quo_reg [NSTG];

    // Two zero alphas weigh both pixels equally.
    always_comb
    begin
        both_zero = (wp == '0) && (wq == '0);
        wp_eff    = both_zero ? awqd_pkg::CHAN_W'(1) : wp;
        wq_eff    = both_zero ? awqd_pkg::CHAN_W'(1) : wq;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            prodp_reg <= PROD_W'(cp) * PROD_W'(wp_eff);
            prodq_reg <= PROD_W'(cq) * PROD_W'(wq_eff);
            dena_reg  <= DEN_W'(wp_eff) + DEN_W'(wq_eff);
            num_reg   <= NUM_W'(prodp_reg) + NUM_W'(prodq_reg);
            denb_reg  <= dena_reg;
        end
    end

    // The quotient never exceeds 255, so eight restoring steps suffice.
    for (genvar s = 0; s < NSTG; s++)
    begin : g_div
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QBITS-1:0] quo_in;
        logic [NUM_W-1:0] rem_out;
        logic [QBITS-1:0] quo_out;
        logic [NUM_W-1:0] trial;

        if (s == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign den_in = denb_reg;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = dvs_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        always_comb
        begin
            rem_out = rem_in;
            quo_out = quo_in;
            trial   = '0;
            for (int k = 0; k < NBITS; k++)
            begin
                trial = NUM_W'(den_in) << (QBITS - 1 - (s * NBITS + k));
                if (rem_out >= trial)
                begin
                    rem_out = rem_out - trial;
                    quo_out = {quo_out[QBITS-2:0], 1'b1};
                end
                else
                begin
                    quo_out = {quo_out[QBITS-2:0], 1'b0};
                end
            end
        end

        if (s < NSTG - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[s] <= rem_out;
                    dvs_reg[s] <= den_in;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                quo_reg[s] <= quo_out;
            end
        end
    end

    assign q = quo_reg[NSTG-1];

endmodule

[rtl/awqd_merge.sv]
// ============================================================================
// awqd_merge
// Combines the top and bottom pair results into the output pixel.
// ============================================================================
module awqd_merge
(
    input  logic                         clk,
    input  logic                         ce,
    input  awqd_pkg::pair_flags_t        flags,
    input  logic [awqd_pkg::CHAN_W-1:0]  top_chan [awqd_pkg::NUM_CHAN],
    input  logic [awqd_pkg::CHAN_W-1:0]  bot_chan [awqd_pkg::NUM_CHAN],
    output logic [awqd_pkg::PIX_W-1:0]   pixel
);

    localparam int CW = awqd_pkg::CHAN_W;

    logic [CW-1:0]                  chan_next [awqd_pkg::NUM_CHAN];
    logic [CW-1:0]                  alpha_next;
    logic [awqd_pkg::PIX_W-1:0]     pixel_reg;

    // Pair results carry alpha 255 or 0. An opaque result beside a clear one
    // wins outright; two of a kind average with equal weight.
    always_comb
    begin
        for (int c = 0; c < awqd_pkg::NUM_CHAN; c++)
        begin
            case ({flags.top_clear, flags.bot_clear})
                2'b01:   chan_next[c] = top_chan[c];
                2'b10:   chan_next[c] = bot_chan[c];
                default: chan_next[c] = CW'(((CW+1)'(top_chan[c]) + (CW+1)'(bot_chan[c])) >> 1);
            endcase
        end
        alpha_next = (flags.top_clear && flags.bot_clear) ? awqd_pkg::ALPHA_CLEAR
                                                          : awqd_pkg::ALPHA_OPAQUE;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pixel_reg <= {alpha_next, chan_next[2], chan_next[1], chan_next[0]};
        end
    end

    assign pixel = pixel_reg;

endmodule

[rtl/awqd_skid.sv]
// ============================================================================
// awqd_skid
// Output register with a skid entry, so the pipeline's stall comes from a
// register rather than from the downstream ready.
// ============================================================================
module awqd_skid
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [awqd_pkg::PIX_W-1:0]   in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [awqd_pkg::PIX_W-1:0]   out_data
);

    logic                         out_valid_reg;
    logic                         skid_valid_reg;
    logic [awqd_pkg::PIX_W-1:0]   out_data_reg;
    logic [awqd_pkg::PIX_W-1:0]   skid_data_reg;
    logic                         push;
    logic                         pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= in_data;
            end
            else
            begin
                skid_data_reg <= in_data;
            end
        end
        else if (pop && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/alpha_weighted_quad_downsample_core.sv]
// ============================================================================
// alpha_weighted_quad_downsample_core
// Alpha-weighted 2x2 box filter producing one mipmap pixel per quad.
// ============================================================================
// Usage: each input word on the slave channel carries one 2x2 quad of ARGB
// pixels; each output word on the master channel carries the reduced ARGB
// pixel. The top pair and the bottom pair are each reduced to an alpha-weighted
// mean per color channel, and the two pair results are then averaged, with a
// fully transparent pair result dropping out next to an opaque one.
// Six lanes (three color channels for each of the two pairs) run side by side.
// Each lane forms the weighted sum in two registered steps and then divides by
// the alpha sum in a four-stage restoring divider, two quotient bits a stage.
// A merge stage combines the pairs and an output register with a skid entry
// holds the result.
// An accepted quad passes the lane registers, the merge register and the output
// register before it can be taken. Throughput is one quad per cycle while s_tready
// is high, set by the fully pipelined divider in every lane.
// Reset clears the valid flags of the pipeline and the output stage; no data
// is cleared. When the receiver stalls, the output word holds, one more word
// lands in the skid entry, and then s_tready drops and the whole pipeline
// freezes until the output word is taken.
module alpha_weighted_quad_downsample_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    // top_left_pixel[31:0], top_right_pixel[63:32],
    // bottom_right_pixel[95:64], bottom_left_pixel[127:96]
    input  logic [127:0]   s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // reduced_pixel[31:0]
    output logic [31:0]    m_tdata
);

    localparam int CW = awqd_pkg::CHAN_W;
    localparam int PW = awqd_pkg::PIX_W;
    localparam int NC = awqd_pkg::NUM_CHAN;

    logic [PW-1:0] tl_pix;
    logic [PW-1:0] tr_pix;
    logic [PW-1:0] br_pix;
    logic [PW-1:0] bl_pix;

    logic ce;

    logic [awqd_pkg::PIPE_LAT-1:0] vld_reg;
    awqd_pkg::pair_flags_t         flg_reg [awqd_pkg::LANE_LAT];
    awqd_pkg::pair_flags_t         flg_next;

    logic [CW-1:0] top_chan [NC];
    logic [CW-1:0] bot_chan [NC];
    logic [PW-1:0] merged_pix;

    assign tl_pix = s_tdata[31:0];
    assign tr_pix = s_tdata[63:32];
    assign br_pix = s_tdata[95:64];
    assign bl_pix = s_tdata[127:96];

    // The pipeline moves as a whole whenever the skid entry is free.
    assign s_tready = ce;

    // A pair whose alphas are both zero comes out transparent.
    always_comb
    begin
        flg_next.top_clear = (tl_pix[PW-1 -: CW] == '0) && (tr_pix[PW-1 -: CW] == '0);
        flg_next.bot_clear = (br_pix[PW-1 -: CW] == '0) && (bl_pix[PW-1 -: CW] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[awqd_pkg::PIPE_LAT-2:0], s_tvalid};
        end
    end

    // The transparency flags ride alongside the lanes.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            flg_reg[0] <= flg_next;
            for (int i = 1; i < awqd_pkg::LANE_LAT; i++)
            begin
                flg_reg[i] <= flg_reg[i-1];
            end
        end
    end

    for (genvar c = 0; c < NC; c++)
    begin : g_chan
        awqd_lane u_top_lane
        (
            .clk (clk),
            .ce  (ce),
            .cp  (tl_pix[c*CW +: CW]),
            .cq  (tr_pix[c*CW +: CW]),
            .wp  (tl_pix[PW-1 -: CW]),
            .wq  (tr_pix[PW-1 -: CW]),
            .q   (top_chan[c])
        );

        awqd_lane u_bot_lane
        (
            .clk (clk),
            .ce  (ce),
            .cp  (br_pix[c*CW +: CW]),
            .cq  (bl_pix[c*CW +: CW]),
            .wp  (br_pix[PW-1 -: CW]),
            .wq  (bl_pix[PW-1 -: CW]),
            .q   (bot_chan[c])
        );
    end

    awqd_merge u_merge
    (
        .clk      (clk),
        .ce       (ce),
        .flags    (flg_reg[awqd_pkg::LANE_LAT-1]),
        .top_chan (top_chan),
        .bot_chan (bot_chan),
        .pixel    (merged_pix)
    );

    awqd_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[awqd_pkg::PIPE_LAT-1]),
        .in_ready  (ce),
        .in_data   (merged_pix),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

[rtl/awqd_checker.sv]
// ============================================================================
// awqd_checker
// Port-level checks for the quad downsampler, bound to the top level.
// ============================================================================
module awqd_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [127:0]   s_tdata,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [31:0]    m_tdata
);

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Every reduced pixel is either fully opaque or fully transparent.
    a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:24] == awqd_pkg::ALPHA_OPAQUE) ||
                     (m_tdata[31:24] == awqd_pkg::ALPHA_CLEAR))
        else $error("reduced pixel has an intermediate alpha");

    // With the output stage empty the skid entry is empty too, so the input
    // side must be open.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output stage is empty");

    // The input cannot stay blocked once the stalled output word is taken.
    a_unblock: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tvalid && m_tready |=> s_tready)
        else $error("input still blocked after output word was taken");

endmodule

bind alpha_weighted_quad_downsample_core awqd_checker u_awqd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
